### sv/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int TAB_STEP    = 4;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [3:0] FG_RESET = 4'h0;
  localparam logic [3:0] BG_RESET = 4'hF;

  // configuration register indexes
  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_offset;
    logic [15:0] cell_value;
    logic        scrolled;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic put;
    logic clear;
    logic copy;
    logic drain;
    logic fill;
    logic capture;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  scroll;
    logic  copy_last;
    logic  fill_last;
  } sts_t;

endpackage

`default_nettype wire

### sv/text_console_writer_top.sv
// Top level of the text console writer: controller plus datapath.
// Write: decode, check and finish states lie between the accepting edge and the next possible
// accept; done_o is registered from the finish state. Read or unused mode: decode and finish states.
// Results cannot be stalled. A scrolling write adds one copy per cell above the bottom row,
// a drain step, then a fill of each bottom-row cell. A clear fills every cell in turn.
// Reset homes the cursor and loads the default colours; the cell store is not cleared.
`default_nettype none

module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire tcw_pkg::req_t req_i,
  output logic               done_o,
  output tcw_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [3:0]    cfg_data_i
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

### sv/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  input  wire tcw_pkg::sts_t sts_i,
  output tcw_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_COPY,
    S_DRAIN,
    S_FILL,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.mode)
          tcw_pkg::MODE_WRITE: begin
            cmd_o.put = 1'b1;
            state_d   = S_CHECK;
          end
          tcw_pkg::MODE_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = S_FILL;
          end
          tcw_pkg::MODE_READ: state_d = S_FINISH;
          tcw_pkg::MODE_NONE: state_d = S_FINISH;
        endcase
      end
      S_CHECK: begin
        state_d = sts_i.scroll ? S_COPY : S_FINISH;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = S_FILL;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.capture = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= (state_q == S_FINISH);
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### sv/tcw_dp.sv
// Datapath of the text console writer: cell store, cursor, sweep pointer, result.
`default_nettype none

module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tcw_pkg::req_t req_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [3:0]    cfg_data_i,
  input  wire tcw_pkg::cmd_t cmd_i,
  output tcw_pkg::sts_t      sts_o,
  output tcw_pkg::rsp_t      rsp_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int NCOPY = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CQW   = $clog2(COLUMNS);
  localparam int CW    = $clog2(COLUMNS + tcw_pkg::TAB_STEP);
  localparam int RQW   = $clog2(ROWS);
  localparam int RW    = $clog2(ROWS + 1);

  logic [15:0] mem_q [CELLS];
  logic [15:0] rd_q;

  tcw_pkg::req_t req_q;
  tcw_pkg::rsp_t rsp_q;
  logic          in_range_q;
  logic [3:0]    fg_q, bg_q;
  logic [CQW-1:0] col_q;
  logic [RQW-1:0] row_q;
  logic           scroll_q;
  logic [AW-1:0]  ptr_q;
  logic           pend_q;
  logic [AW-1:0]  pend_addr_q;

  logic [CW-1:0]  col_n;
  logic [RW-1:0]  row_n;
  logic           scroll_n;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  idx_addr;
  logic [AW+10:0] idx_ext;
  logic [AW+10:0] req_idx_ext;
  logic [AW-1:0]  raddr, waddr;
  logic [15:0]    wdata;
  logic           we;
  logic [7:0]     attr;
  logic           ordinary;
  logic [RQW+4:0] row_ext;
  logic [CQW+6:0] col_ext;
  logic [AW+10:0] off_ext;

  assign attr     = {fg_q, bg_q};
  assign ordinary = (req_q.char_code != tcw_pkg::CH_NEWLINE) &&
                    (req_q.char_code != tcw_pkg::CH_TAB);
  assign cur_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

  assign idx_ext     = {{AW{1'b0}}, req_q.cell_index};
  assign idx_addr    = idx_ext[AW-1:0];
  assign req_idx_ext = {{AW{1'b0}}, req_i.cell_index};

  // cursor step for a written character
  always_comb begin
    col_n    = CW'(col_q);
    row_n    = RW'(row_q);
    scroll_n = 1'b0;
    if (req_q.char_code == tcw_pkg::CH_NEWLINE) begin
      row_n = RW'(row_q) + RW'(1);
      col_n = '0;
    end else if (req_q.char_code == tcw_pkg::CH_TAB) begin
      col_n = CW'(col_q) + CW'(tcw_pkg::TAB_STEP);
    end else begin
      col_n = CW'(col_q) + CW'(1);
    end
    // tab overshoot is dropped
    if (col_n >= CW'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + RW'(1);
    end
    if (row_n >= RW'(ROWS)) begin
      row_n    = RW'(ROWS - 1);
      scroll_n = 1'b1;
    end
  end

  // store port mux: pending copy beats fill beats character
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {attr, req_q.char_code};
    if (pend_q) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      wdata = rd_q;
    end else if (cmd_i.fill) begin
      we    = 1'b1;
      waddr = ptr_q;
      wdata = {attr, tcw_pkg::CH_SPACE};
    end else if (cmd_i.put && ordinary) begin
      we = 1'b1;
    end
  end

  assign raddr = cmd_i.copy ? (ptr_q + AW'(COLUMNS)) : idx_addr;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q     <= tcw_pkg::FG_RESET;
      bg_q     <= tcw_pkg::BG_RESET;
      col_q    <= '0;
      row_q    <= '0;
      scroll_q <= 1'b0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcw_pkg::CFG_FOREGROUND: fg_q <= cfg_data_i;
          tcw_pkg::CFG_BACKGROUND: bg_q <= cfg_data_i;
        endcase
      end
      pend_q <= cmd_i.copy;
      if (cmd_i.latch) begin
        ptr_q    <= '0;
        scroll_q <= 1'b0;
      end
      if (cmd_i.put) begin
        col_q    <= col_n[CQW-1:0];
        row_q    <= row_n[RQW-1:0];
        scroll_q <= scroll_n;
      end
      if (cmd_i.clear) begin
        col_q <= '0;
        row_q <= '0;
      end
      if (cmd_i.copy || cmd_i.fill) ptr_q <= ptr_q + AW'(1);
      // bottom row starts right after the copied rows
      if (cmd_i.drain) ptr_q <= AW'(NCOPY);
    end
  end

  assign row_ext = {5'b0, row_q};
  assign col_ext = {7'b0, col_q};
  assign off_ext = {11'b0, cur_addr};

  always_ff @(posedge clk_i) begin
    pend_addr_q <= ptr_q;
    if (cmd_i.latch) begin
      req_q      <= req_i;
      in_range_q <= (req_idx_ext < (AW + 11)'(CELLS));
    end
    if (cmd_i.capture) begin
      rsp_q.cursor_row    <= row_ext[4:0];
      rsp_q.cursor_column <= col_ext[6:0];
      rsp_q.cursor_offset <= off_ext[10:0];
      rsp_q.cell_value    <= (req_q.mode == tcw_pkg::MODE_READ && in_range_q) ? rd_q : 16'h0;
      rsp_q.scrolled      <= scroll_q;
    end
  end

  assign sts_o.mode      = req_q.mode;
  assign sts_o.scroll    = scroll_q;
  assign sts_o.copy_last = (ptr_q == AW'(NCOPY - 1));
  assign sts_o.fill_last = (ptr_q == AW'(CELLS - 1));
  assign rsp_o           = rsp_q;

endmodule

`default_nettype wire

### sv/tcw_checker.sv
// Port-level checks of the text console writer and their bind.
`default_nettype none

module tcw_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire tcw_pkg::rsp_t rsp_o
);

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // a result only shows once the block is idle again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // finishing a request always delivers its result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_rsp_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(rsp_o))
    else $error("unknown bits in result");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the text console writer: directed table, then random text.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } vec_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       done_o;
  rsp_t       rsp_o;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [3:0] cfg_data_i;

  // console image as the hardware should hold it
  logic [15:0] screen_img [CELLS];
  int          cur_row;
  int          cur_col;
  logic [3:0]  fg_now;
  logic [3:0]  bg_now;
  bit          screen_ready;

  rsp_t        want_q [$];
  vec_t        dir_q [$];
  int          mismatches;
  int          cycles;
  int          burst_left;
  bit          burst_newline;

  text_console_writer_top i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .done_o,
    .rsp_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL text_console_writer_top");
      $finish;
    end
  end

  task automatic log_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic rsp_t predict_console(req_t r);
    rsp_t       o;
    logic [15:0] blank;
    int          i;
    o = '0;
    blank = {fg_now, bg_now, CH_SPACE};
    case (r.mode)
      MODE_WRITE: begin
        if (r.char_code == CH_NEWLINE) begin
          cur_row++;
          cur_col = 0;
        end else if (r.char_code == CH_TAB) begin
          cur_col += TAB_STEP;
        end else begin
          screen_img[cur_row * COLUMNS + cur_col] = {fg_now, bg_now, r.char_code};
          cur_col++;
        end
        // tab overshoot is dropped on wrap
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen_img[i] = blank;
          cur_row = ROWS - 1;
          o.scrolled = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_img[i] = blank;
        cur_row = 0;
        cur_col = 0;
        screen_ready = 1'b1;
      end
      MODE_READ: begin
        if (r.cell_index < CELLS) o.cell_value = screen_img[r.cell_index];
      end
      default: ;
    endcase
    o.cursor_row    = 5'(cur_row);
    o.cursor_column = 7'(cur_col);
    o.cursor_offset = 11'(cur_row * COLUMNS + cur_col);
    return o;
  endfunction

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (want_q.size() == 0) begin
        log_mismatch("unexpected result", 16'(rsp_o.cursor_offset), '0);
      end else begin
        want = want_q.pop_front();
        if (rsp_o.cursor_row !== want.cursor_row)
          log_mismatch("cursor_row", 16'(rsp_o.cursor_row), 16'(want.cursor_row));
        if (rsp_o.cursor_column !== want.cursor_column)
          log_mismatch("cursor_column", 16'(rsp_o.cursor_column), 16'(want.cursor_column));
        if (rsp_o.cursor_offset !== want.cursor_offset)
          log_mismatch("cursor_offset", 16'(rsp_o.cursor_offset), 16'(want.cursor_offset));
        if (rsp_o.cell_value !== want.cell_value)
          log_mismatch("cell_value", rsp_o.cell_value, want.cell_value);
        if (rsp_o.scrolled !== want.scrolled)
          log_mismatch("scrolled", 16'(rsp_o.scrolled), 16'(want.scrolled));
      end
    end
  end

  // request is accepted at the edge where start is high and busy is low
  task automatic issue_req(input req_t r, input logic typed, input rsp_t given);
    rsp_t p;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    p = predict_console(r);
    want_q.push_back(typed ? given : p);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    do @(posedge clk_i); while (want_q.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_colours(input logic [3:0] fg, input logic [3:0] bg);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FOREGROUND;
    cfg_data_i <= fg;
    @(posedge clk_i);
    fg_now = fg;
    cfg_idx_i  <= CFG_BACKGROUND;
    cfg_data_i <= bg;
    @(posedge clk_i);
    bg_now = bg;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_vec(mode_e m, logic [7:0] ch, logic [10:0] idx, logic typed,
                                  int r, int c, logic [15:0] val);
    vec_t v;
    v.req.mode            = m;
    v.req.char_code       = ch;
    v.req.cell_index      = idx;
    v.typed               = typed;
    v.want.cursor_row     = 5'(r);
    v.want.cursor_column  = 7'(c);
    v.want.cursor_offset  = 11'(r * COLUMNS + c);
    v.want.cell_value     = val;
    v.want.scrolled       = 1'b0;
    dir_q.push_back(v);
  endfunction

  // mostly text runs and newline bursts, with reads, clears and noise mixed in
  function automatic req_t pick_req();
    req_t r;
    int   roll;
    r.mode       = MODE_WRITE;
    r.char_code  = 8'($urandom);
    r.cell_index = 11'($urandom);
    if (burst_left > 0) begin
      burst_left--;
      if (burst_newline) r.char_code = CH_NEWLINE;
      else if ($urandom_range(0, 9) == 0) r.char_code = CH_TAB;
      else r.char_code = 8'($urandom_range(8'h20, 8'h7e));
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      burst_newline = 1'b1;
      burst_left    = $urandom_range(5, 30);
      r.char_code   = CH_NEWLINE;
    end else if (roll < 6) begin
      burst_newline = 1'b0;
      burst_left    = $urandom_range(40, 100);
    end else if (roll < 7) begin
      r.mode = MODE_CLEAR;
    end else if (roll < 9) begin
      r.mode = MODE_NONE;
    end else if (roll < 25) begin
      r.mode = MODE_READ;
      // never touch cells before the first clear
      if (screen_ready && roll >= 11) r.cell_index = 11'($urandom_range(0, CELLS - 1));
      else r.cell_index = 11'($urandom_range(CELLS, 2047));
    end else if (roll < 33) begin
      r.char_code = CH_NEWLINE;
    end else if (roll < 40) begin
      r.char_code = CH_TAB;
    end
    return r;
  endfunction

  // before each request the sender holds off while a draw of 0..99 falls below idle_pct
  task automatic run_phase(input int n, input int idle_pct);
    req_t r;
    for (int k = 0; k < n; k++) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      r = pick_req();
      issue_req(r, 1'b0, '0);
      if ($urandom_range(0, 49) == 0) drain_requests();
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    req_i      <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_FOREGROUND;
    cfg_data_i <= '0;
    cur_row      = 0;
    cur_col      = 0;
    fg_now       = FG_RESET;
    bg_now       = BG_RESET;
    screen_ready = 1'b0;
    mismatches   = 0;
    cycles       = 0;
    burst_left   = 0;
    foreach (screen_img[i]) screen_img[i] = '0;

    // reset colours give attribute 0x0F
    add_vec(MODE_NONE,  8'hFF, 11'h7FF, 1'b1, 0, 0, 16'h0000);
    add_vec(MODE_READ,  8'h00, 11'h7FF, 1'b1, 0, 0, 16'h0000);
    add_vec(MODE_READ,  8'h00, 11'd2000, 1'b1, 0, 0, 16'h0000);
    add_vec(MODE_CLEAR, 8'hFF, 11'h7FF, 1'b1, 0, 0, 16'h0000);
    add_vec(MODE_READ,  8'h00, 11'd0,    1'b1, 0, 0, 16'h0F20);
    add_vec(MODE_READ,  8'hFF, 11'd1999, 1'b1, 0, 0, 16'h0F20);
    add_vec(MODE_WRITE, 8'h41, 11'd0,    1'b1, 0, 1, 16'h0000);
    add_vec(MODE_WRITE, 8'hFF, 11'h7FF,  1'b1, 0, 2, 16'h0000);
    add_vec(MODE_WRITE, 8'h00, 11'd0,    1'b1, 0, 3, 16'h0000);
    add_vec(MODE_WRITE, CH_TAB, 11'd5,   1'b1, 0, 7, 16'h0000);
    add_vec(MODE_WRITE, CH_NEWLINE, 11'd9, 1'b1, 1, 0, 16'h0000);
    add_vec(MODE_READ,  8'h00, 11'd0,    1'b1, 1, 0, 16'h0F41);
    add_vec(MODE_READ,  8'h00, 11'd1,    1'b1, 1, 0, 16'h0FFF);
    add_vec(MODE_READ,  8'h00, 11'd2,    1'b1, 1, 0, 16'h0F00);
    add_vec(MODE_READ,  8'h00, 11'd3,    1'b1, 1, 0, 16'h0F20);
    add_vec(MODE_WRITE, CH_TAB, 11'd0,   1'b1, 1, 4, 16'h0000);
    add_vec(MODE_WRITE, 8'h7E, 11'd0,    1'b0, 0, 0, 16'h0000);
    add_vec(MODE_WRITE, 8'h80, 11'd0,    1'b0, 0, 0, 16'h0000);
    add_vec(MODE_READ,  8'h00, 11'd84,   1'b0, 0, 0, 16'h0000);
    add_vec(MODE_READ,  8'h00, 11'd85,   1'b0, 0, 0, 16'h0000);
    add_vec(MODE_READ,  8'h00, 11'd1024, 1'b0, 0, 0, 16'h0000);
    add_vec(MODE_WRITE, CH_NEWLINE, 11'h400, 1'b0, 0, 0, 16'h0000);
    add_vec(MODE_NONE,  8'h00, 11'd0,    1'b0, 0, 0, 16'h0000);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) issue_req(dir_q[i].req, dir_q[i].typed, dir_q[i].want);
    drain_requests();

    set_colours(4'hF, 4'h0);
    run_phase(217, 31);
    drain_requests();

    set_colours(4'($urandom), 4'($urandom));
    run_phase(217, 79);
    drain_requests();

    set_colours(4'h0, 4'hF);
    run_phase(216, 0);
    drain_requests();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS text_console_writer_top");
    end else begin
      $display("FAIL text_console_writer_top");
    end
    $finish;
  end

endmodule
